@@ design/rssg_pkg.sv @@
// Package for the rover speed safety governor.
// Types, codes and constants shared by the divider and the top level.
package rssg_pkg;

   localparam int DIV_W = 64;
   localparam int DIV_CW = 7;

   localparam logic [1:0] OP_RAY   = 2'd0;
   localparam logic [1:0] OP_IMU   = 2'd1;
   localparam logic [1:0] OP_CMD   = 2'd2;
   localparam logic [1:0] OP_SPARE = 2'd3;

   localparam logic [2:0] REG_WARN     = 3'd0;
   localparam logic [2:0] REG_CRIT     = 3'd1;
   localparam logic [2:0] REG_INCLINE  = 3'd2;
   localparam logic [2:0] REG_WINDOW   = 3'd3;
   localparam logic [2:0] REG_VAR_MAX  = 3'd4;
   localparam logic [2:0] REG_SECTOR   = 3'd5;
   localparam logic [2:0] REG_CORRIDOR = 3'd6;
   localparam logic [2:0] REG_GRAVITY  = 3'd7;

   localparam logic signed [20:0] FAR_MM = 21'sd999000;
   localparam logic [15:0] Q_ONE = 16'd32768;
   localparam logic [15:0] VIB_FLOOR_Q = 16'd6554;
   localparam logic [35:0] VAR_MAX = 36'hF_FFFF_FFFF;
   localparam logic signed [19:0] C19_MAX = 20'sd262143;
   localparam logic signed [19:0] C19_MIN = -20'sd262144;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RING_RD,
      ST_RING_UPD,
      ST_VAR_NUM,
      ST_VAR_WAIT,
      ST_PROX,
      ST_PROX_WAIT,
      ST_TILT,
      ST_TILT_WAIT,
      ST_VIB,
      ST_VIB_WAIT,
      ST_MUL1,
      ST_MUL2,
      ST_SCALE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  rem0;
      logic [DIV_W-1:0]  dvd;
      logic [DIV_W-1:0]  dsr;
      logic [DIV_CW-1:0] steps;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DIV_W-1:0] quo;
   } div_rsp_type;

   // Quotient known to be below 2^16: start with the top part as the remainder.
   function automatic div_req_type q16_req(input logic [DIV_W-1:0] d,
                                           input logic [DIV_W-1:0] s);
      div_req_type r;
      r.start = 1'b1;
      r.rem0  = d >> 16;
      r.dvd   = {d[15:0], 48'd0};
      r.dsr   = s;
      r.steps = 7'd16;
      return r;
   endfunction

endpackage

@@ design/rssg_req_if.sv @@
// Input item channel of the rover speed safety governor.
// Depends on nothing.
interface rssg_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         op;
   logic signed [12:0] ray_angle_mrad;
   logic signed [16:0] ray_forward_mm;
   logic [15:0]        ray_lateral_mm;
   logic               ray_valid;
   logic               last_ray;
   logic signed [12:0] pitch_mrad;
   logic signed [12:0] roll_mrad;
   logic signed [18:0] accel_z;
   logic signed [15:0] cmd_linear_x;
   logic signed [15:0] cmd_linear_y;
   logic signed [15:0] cmd_angular_z;

   modport source (output valid, op, ray_angle_mrad, ray_forward_mm, ray_lateral_mm,
                   ray_valid, last_ray, pitch_mrad, roll_mrad, accel_z, cmd_linear_x,
                   cmd_linear_y, cmd_angular_z, input ready);
   modport sink (input valid, op, ray_angle_mrad, ray_forward_mm, ray_lateral_mm,
                 ray_valid, last_ray, pitch_mrad, roll_mrad, accel_z, cmd_linear_x,
                 cmd_linear_y, cmd_angular_z, output ready);
endinterface

@@ design/rssg_rsp_if.sv @@
// Result item channel of the rover speed safety governor.
// Depends on nothing.
interface rssg_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] out_linear_x;
   logic signed [15:0] out_linear_y;
   logic signed [15:0] out_angular_z;
   logic [15:0]        multiplier;

   modport source (output valid, out_linear_x, out_linear_y, out_angular_z, multiplier,
                   input ready);
   modport sink (input valid, out_linear_x, out_linear_y, out_angular_z, multiplier,
                 output ready);
endinterface

@@ design/rssg_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on rssg_pkg.
module rssg_div
   import rssg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  dvd_ff, dvd_in;
   logic [DIV_W-1:0]  dsr_ff, dsr_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DIV_CW-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIV_W:0]    shifted;
   logic [DIV_W:0]    trial;

   always_comb begin
      shifted = {rem_ff, dvd_ff[DIV_W-1]};
      trial   = shifted - {1'b0, dsr_ff};
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = req.rem0;
         dvd_in  = req.dvd;
         dsr_in  = req.dsr;
         quo_in  = '0;
         cnt_in  = req.steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DIV_W-2:0], 1'b0};
         if (!trial[DIV_W]) begin
            rem_in = trial[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;

endmodule

@@ design/rover_speed_safety_governor_top.sv @@
// Rover speed safety governor, top level.
// Depends on rssg_pkg, rssg_req_if, rssg_rsp_if and rssg_div.
//
// An inertial sample is a read and write back of the acceleration ring memory, then,
// once the window holds more than one sample, a 64-step division for the window
// variance. A velocity command takes up to three
// 16-step divisions (proximity, tilt, vibration factor) on the shared divider, two
// multiplier stages and the output scaling. Items are handled one at a time; a
// finished result waits in the output register while the next item is accepted.
// The ring memory holds no reset value and needs no clearing after reset.
module rover_speed_safety_governor_top
   import rssg_pkg::*;
#(
   parameter int WINDOW_DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   rssg_req_if.sink          req_chan,
   rssg_rsp_if.source        rsp_chan,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [35:0]       csr_wdata
);

   localparam int PW   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int CW   = $clog2(WINDOW_DEPTH + 1);
   localparam int SW   = 20 + PW;
   localparam int SQW  = 37 + PW;
   localparam int NUMW = SQW + CW;

   logic [15:0]        warn_ff, crit_ff, corr_ff;
   logic [10:0]        incl_ff;
   logic [6:0]         win_ff;
   logic [35:0]        vmax_ff;
   logic [11:0]        sect_ff;
   logic signed [18:0] grav_ff;

   state_type          state_ff, state_in;
   logic signed [20:0] runmin_ff, near_ff;
   logic signed [12:0] pitch_ff, roll_ff;
   logic [CW-1:0]      count_ff;
   logic [PW-1:0]      ptr_ff;
   logic signed [SW-1:0] sum_ff;
   logic [SQW-1:0]     sq_ff;
   logic [35:0]        var_ff;

   logic [18:0]        ring_mem [WINDOW_DEPTH];
   logic [18:0]        rd_ff;
   logic signed [18:0] z_ff;
   logic signed [15:0] cx_ff, cy_ff, cw_ff;
   logic [15:0]        prox_ff, tilt_ff, vib_ff;
   logic [16:0]        m1_ff;
   logic [15:0]        mul_ff;
   logic signed [15:0] sx_ff, sy_ff, sw_ff;

   logic               out_valid_ff;
   logic signed [15:0] out_x_ff, out_y_ff, out_w_ff;
   logic [15:0]        out_m_ff;

   div_req_type        div_req;
   div_rsp_type        div_rsp;

   rssg_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   logic accept;
   logic out_free;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept = req_chan.valid && req_chan.ready;
   assign out_free = !out_valid_ff || rsp_chan.ready;

   // window length
   logic [CW-1:0] len;
   always_comb begin
      if (win_ff < 7'd2) len = CW'(2);
      else if (32'(win_ff) > WINDOW_DEPTH) len = CW'(WINDOW_DEPTH);
      else len = CW'(win_ff);
   end

   // ray filter
   logic [12:0]        ang_abs;
   logic               ray_ok;
   logic signed [20:0] fwd_ext;
   assign ang_abs = req_chan.ray_angle_mrad[12] ? 13'(-req_chan.ray_angle_mrad)
                                                 : 13'(req_chan.ray_angle_mrad);
   assign fwd_ext = 21'(req_chan.ray_forward_mm);
   assign ray_ok  = req_chan.ray_valid && (ang_abs < {1'b0, sect_ff})
                    && (req_chan.ray_lateral_mm < corr_ff);

   // centred acceleration
   logic signed [19:0] zc;
   logic signed [18:0] z_sat;
   always_comb begin
      zc = 20'(req_chan.accel_z) - 20'(grav_ff);
      if (zc > C19_MAX) z_sat = 19'(C19_MAX);
      else if (zc < C19_MIN) z_sat = 19'(C19_MIN);
      else z_sat = 19'(zc);
   end

   // ring update
   logic signed [18:0] old_s;
   logic [18:0]        old_abs, z_abs;
   logic [SQW-1:0]     old_sq, z_sq;
   logic               full;
   logic signed [SW-1:0] sum_in;
   logic [SQW-1:0]     sq_in;
   logic [PW-1:0]      ptr_in;
   always_comb begin
      old_s   = signed'(rd_ff);
      old_abs = old_s[18] ? 19'(-old_s) : 19'(old_s);
      z_abs   = z_ff[18] ? 19'(-z_ff) : 19'(z_ff);
      old_sq  = SQW'({19'd0, old_abs} * {19'd0, old_abs});
      z_sq    = SQW'({19'd0, z_abs} * {19'd0, z_abs});
      full    = (count_ff >= len);
      sum_in  = sum_ff + SW'(z_ff);
      sq_in   = sq_ff + z_sq;
      if (full) begin
         sum_in = sum_in - SW'(old_s);
         sq_in  = sq_in - old_sq;
      end
      ptr_in = ((CW'(ptr_ff) + CW'(1)) == len) ? '0 : ptr_ff + 1'b1;
   end

   // variance numerator
   logic [SW-1:0]    s_abs;
   logic [NUMW-1:0]  nsq;
   logic [2*SW-1:0]  ssq;
   logic [DIV_W-1:0] var_num;
   logic [2*CW-1:0]  var_den;
   logic             var_div;
   always_comb begin
      s_abs   = sum_ff[SW-1] ? SW'(-sum_ff) : SW'(sum_ff);
      nsq     = NUMW'(count_ff) * NUMW'(sq_ff);
      ssq     = (2*SW)'(s_abs) * (2*SW)'(s_abs);
      var_num = DIV_W'(nsq) - DIV_W'(ssq);
      var_den = (2*CW)'(count_ff) * (2*CW)'(count_ff - 1'b1);
      var_div = (count_ff > CW'(1));
   end

   // proximity factor
   logic signed [21:0] dc, dw;
   logic               prox_zero, prox_div;
   logic [DIV_W-1:0]   prox_d, prox_s;
   always_comb begin
      dc        = 22'(near_ff) - signed'({6'd0, crit_ff});
      dw        = 22'(near_ff) - signed'({6'd0, warn_ff});
      prox_zero = (dc <= 22'sd0);
      prox_div  = !prox_zero && (dw < 22'sd0);
      prox_d    = DIV_W'(dc[15:0]) << 15;
      prox_s    = DIV_W'(warn_ff - crit_ff);
   end

   // tilt factor
   logic [12:0]      p_abs, r_abs, tilt;
   logic             tilt_zero, tilt_div;
   logic [DIV_W-1:0] tilt_d;
   always_comb begin
      p_abs     = pitch_ff[12] ? 13'(-pitch_ff) : 13'(pitch_ff);
      r_abs     = roll_ff[12] ? 13'(-roll_ff) : 13'(roll_ff);
      tilt      = (p_abs > r_abs) ? p_abs : r_abs;
      tilt_zero = (tilt > {2'd0, incl_ff});
      tilt_div  = !tilt_zero && ({tilt, 1'b0} > {3'd0, incl_ff}) && (incl_ff != 11'd0);
      tilt_d    = DIV_W'(11'({2'd0, incl_ff} - tilt)) << 16;
   end

   // vibration factor
   logic [DIV_W-1:0] v10, vm3, vib_den, vib_num, vib_d;
   logic             vib_floor, vib_div;
   always_comb begin
      v10       = DIV_W'(var_ff) * DIV_W'(10);
      vm3       = DIV_W'(vmax_ff) * DIV_W'(3);
      vib_floor = (var_ff > vmax_ff);
      vib_div   = !vib_floor && (v10 > vm3) && (vmax_ff != 36'd0);
      vib_den   = DIV_W'(vmax_ff) * DIV_W'(70);
      vib_num   = (v10 - vm3) << 18;
      vib_d     = (vib_den << 15) - vib_num;
   end

   // scaling
   logic [16:0] x_abs, y_abs, w_abs;
   logic [32:0] x_p, y_p, w_p;
   always_comb begin
      x_abs = cx_ff[15] ? 17'(-cx_ff) : 17'(cx_ff);
      y_abs = cy_ff[15] ? 17'(-cy_ff) : 17'(cy_ff);
      w_abs = cw_ff[15] ? 17'(-cw_ff) : 17'(cw_ff);
      x_p   = (33'(x_abs) * 33'(mul_ff)) >> 15;
      y_p   = (33'(y_abs) * 33'(mul_ff)) >> 15;
      w_p   = (33'(w_abs) * 33'(mul_ff)) >> 15;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_chan.op == OP_IMU) state_in = ST_RING_RD;
               else if (req_chan.op == OP_CMD) state_in = ST_PROX;
            end
         end
         ST_RING_RD:   state_in = ST_RING_UPD;
         ST_RING_UPD:  state_in = ST_VAR_NUM;
         ST_VAR_NUM:   state_in = var_div ? ST_VAR_WAIT : ST_IDLE;
         ST_VAR_WAIT:  if (div_rsp.done) state_in = ST_IDLE;
         ST_PROX:      state_in = prox_div ? ST_PROX_WAIT : ST_TILT;
         ST_PROX_WAIT: if (div_rsp.done) state_in = ST_TILT;
         ST_TILT:      state_in = tilt_div ? ST_TILT_WAIT : ST_VIB;
         ST_TILT_WAIT: if (div_rsp.done) state_in = ST_VIB;
         ST_VIB:       state_in = vib_div ? ST_VIB_WAIT : ST_MUL1;
         ST_VIB_WAIT:  if (div_rsp.done) state_in = ST_MUL1;
         ST_MUL1:      state_in = ST_MUL2;
         ST_MUL2:      state_in = ST_SCALE;
         ST_SCALE:     state_in = ST_OUT;
         ST_OUT:       if (out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // divider requests
   always_comb begin
      div_req = '0;
      unique case (state_ff)
         ST_VAR_NUM: begin
            if (var_div) begin
               div_req.start = 1'b1;
               div_req.rem0  = '0;
               div_req.dvd   = var_num;
               div_req.dsr   = DIV_W'(var_den);
               div_req.steps = DIV_CW'(DIV_W);
            end
         end
         ST_PROX: if (prox_div) div_req = q16_req(prox_d, prox_s);
         ST_TILT: if (tilt_div) div_req = q16_req(tilt_d, DIV_W'(incl_ff));
         ST_VIB:  if (vib_div) div_req = q16_req(vib_d, vib_den);
         default: div_req = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_RING_UPD) ring_mem[ptr_ff] <= z_ff;
      if (state_ff == ST_RING_RD) rd_ff <= ring_mem[ptr_ff];
   end

   logic [16:0] m2;
   assign m2 = 17'((33'(m1_ff) * 33'(vib_ff)) >> 15);

   always_ff @(posedge clock) begin
      if (accept) begin
         z_ff  <= z_sat;
         cx_ff <= req_chan.cmd_linear_x;
         cy_ff <= req_chan.cmd_linear_y;
         cw_ff <= req_chan.cmd_angular_z;
      end
      case (state_ff)
         ST_PROX: if (!prox_div) prox_ff <= prox_zero ? 16'd0 : Q_ONE;
         ST_PROX_WAIT: if (div_rsp.done) prox_ff <= div_rsp.quo[15:0];
         ST_TILT: if (!tilt_div) tilt_ff <= tilt_zero ? 16'd0 : Q_ONE;
         ST_TILT_WAIT: if (div_rsp.done) tilt_ff <= div_rsp.quo[15:0];
         ST_VIB: if (!vib_div) vib_ff <= vib_floor ? VIB_FLOOR_Q : Q_ONE;
         ST_VIB_WAIT: if (div_rsp.done) vib_ff <= div_rsp.quo[15:0];
         ST_MUL1: m1_ff <= 17'((32'(prox_ff) * 32'(tilt_ff)) >> 15);
         ST_MUL2: mul_ff <= (m2 > 17'(Q_ONE)) ? Q_ONE : m2[15:0];
         ST_SCALE: begin
            sx_ff <= (cx_ff > 16'sd0) ? 16'(x_p) : cx_ff;
            sy_ff <= cy_ff[15] ? 16'(-y_p) : 16'(y_p);
            sw_ff <= cw_ff[15] ? 16'(-w_p) : 16'(w_p);
         end
         default: ;
      endcase
      if (state_ff == ST_OUT && out_free) begin
         out_x_ff <= sx_ff;
         out_y_ff <= sy_ff;
         out_w_ff <= sw_ff;
         out_m_ff <= mul_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         warn_ff      <= 16'd2000;
         crit_ff      <= 16'd600;
         incl_ff      <= 11'd314;
         win_ff       <= 7'd50;
         vmax_ff      <= 36'd4000000;
         sect_ff      <= 12'd524;
         corr_ff      <= 16'd400;
         grav_ff      <= 19'sd9810;
         runmin_ff    <= FAR_MM;
         near_ff      <= FAR_MM;
         pitch_ff     <= '0;
         roll_ff      <= '0;
         count_ff     <= '0;
         ptr_ff       <= '0;
         sum_ff       <= '0;
         sq_ff        <= '0;
         var_ff       <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_OUT && out_free) out_valid_ff <= 1'b1;
         else if (rsp_chan.ready) out_valid_ff <= 1'b0;

         if (accept && req_chan.op == OP_RAY) begin
            if (req_chan.last_ray) begin
               near_ff   <= (ray_ok && fwd_ext < runmin_ff) ? fwd_ext : runmin_ff;
               runmin_ff <= FAR_MM;
            end else if (ray_ok && fwd_ext < runmin_ff) begin
               runmin_ff <= fwd_ext;
            end
         end
         if (accept && req_chan.op == OP_IMU) begin
            pitch_ff <= req_chan.pitch_mrad;
            roll_ff  <= req_chan.roll_mrad;
         end
         if (state_ff == ST_RING_UPD) begin
            sum_ff <= sum_in;
            sq_ff  <= sq_in;
            ptr_ff <= ptr_in;
            if (!full) count_ff <= count_ff + 1'b1;
         end
         if (state_ff == ST_VAR_NUM && !var_div) var_ff <= '0;
         if (state_ff == ST_VAR_WAIT && div_rsp.done) begin
            var_ff <= (div_rsp.quo > DIV_W'(VAR_MAX)) ? VAR_MAX : div_rsp.quo[35:0];
         end

         if (csr_we) begin
            unique case (csr_index)
               REG_WARN:     warn_ff <= csr_wdata[15:0];
               REG_CRIT:     crit_ff <= csr_wdata[15:0];
               REG_INCLINE:  incl_ff <= csr_wdata[10:0];
               REG_WINDOW: begin
                  win_ff <= csr_wdata[6:0];
                  if (csr_wdata[6:0] != win_ff) begin
                     count_ff <= '0;
                     ptr_ff   <= '0;
                     sum_ff   <= '0;
                     sq_ff    <= '0;
                  end
               end
               REG_VAR_MAX:  vmax_ff <= csr_wdata;
               REG_SECTOR:   sect_ff <= csr_wdata[11:0];
               REG_CORRIDOR: corr_ff <= csr_wdata[15:0];
               REG_GRAVITY:  grav_ff <= signed'(csr_wdata[18:0]);
               default: ;
            endcase
         end
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.out_linear_x  = out_x_ff;
   assign rsp_chan.out_linear_y  = out_y_ff;
   assign rsp_chan.out_angular_z = out_w_ff;
   assign rsp_chan.multiplier    = out_m_ff;

   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_VAR_WAIT || state_ff == ST_PROX_WAIT ||
                        state_ff == ST_TILT_WAIT || state_ff == ST_VIB_WAIT))
      else $error("divider finished outside a wait state");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= len)
      else $error("window sample count above window length");

   a_mult_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.multiplier <= Q_ONE)
      else $error("multiplier above one");

   a_window_clear: assert property (@(posedge clock) disable iff (reset)
      (csr_we && csr_index == REG_WINDOW && csr_wdata[6:0] != win_ff) |=>
      (count_ff == '0 && sum_ff == '0))
      else $error("window not cleared on length change");

endmodule

@@ tb/rover_speed_safety_governor_top_tb.sv @@
// Self-checking testbench for rover_speed_safety_governor_top: scan rays, inertial samples
// and velocity commands are driven with random stalls and the scaled commands are checked.
// Depends on rssg_pkg, rssg_req_if, rssg_rsp_if and the governor RTL.
`timescale 1ns / 1ps

module rover_speed_safety_governor_top_tb;
   import rssg_pkg::*;

   typedef struct {
      logic [1:0]         op;
      logic signed [12:0] ang;
      logic signed [16:0] fwd;
      logic [15:0]        lat;
      logic               rv;
      logic               lr;
      logic signed [12:0] pitch;
      logic signed [12:0] roll;
      logic signed [18:0] az;
      logic signed [15:0] cx;
      logic signed [15:0] cy;
      logic signed [15:0] cw;
   } gov_item_type;

   typedef struct {
      logic signed [15:0] lx;
      logic signed [15:0] ly;
      logic signed [15:0] wz;
      logic [15:0]        mult;
   } gov_cmd_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [2:0] csr_index = REG_WARN;
   logic [35:0] csr_wdata = '0;

   rssg_req_if req ();
   rssg_rsp_if rsp ();

   rover_speed_safety_governor_top uut (
      .clock(clock), .reset(reset), .req_chan(req), .rsp_chan(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   gov_item_type pending[$];
   gov_cmd_type  scaled_cmds[$];
   int errors = 0;
   int items_sent = 0;
   int cmds_checked = 0;
   int cycles = 0;
   bit quiet = 0;
   bit req_fire = 0;
   int req_gap = 0;
   int rsp_stall = 0;

   // governor mirror: configuration
   longint unsigned g_warn, g_crit, g_incl, g_win, g_vmax, g_sector, g_corr;
   longint g_grav;
   // governor mirror: state
   longint run_min, nearest, pitch_h, roll_h;
   longint ring[64];
   int unsigned n_samples, ring_ptr;
   longint wsum;
   longint unsigned wsq, vib_var;

   function automatic longint labs(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint unsigned prox_q();
      longint c, w;
      c = longint'(g_crit);
      w = longint'(g_warn);
      if (nearest <= c) return 0;
      if (nearest < w) return longint'(((nearest - c) * 32768) / (w - c));
      return 32768;
   endfunction

   function automatic longint unsigned tilt_q();
      longint t, m;
      t = labs(pitch_h) > labs(roll_h) ? labs(pitch_h) : labs(roll_h);
      m = longint'(g_incl);
      if (t > m) return 0;
      if (2 * t > m && m > 0) return longint'(((m - t) * 2 * 32768) / m);
      return 32768;
   endfunction

   function automatic longint unsigned vib_q();
      longint unsigned num, den;
      if (vib_var > g_vmax) return 6554;
      if (10 * vib_var > 3 * g_vmax && g_vmax > 0) begin
         num = 262144 * (10 * vib_var - 3 * g_vmax);
         den = 70 * g_vmax;
         return (32768 * den - num) / den;
      end
      return 32768;
   endfunction

   function automatic logic signed [15:0] scale_q(longint v, longint unsigned m);
      longint unsigned mag;
      mag = (longint'(labs(v)) * m) >> 15;
      return v < 0 ? 16'(-longint'(mag)) : 16'(mag);
   endfunction

   function automatic int unsigned win_len();
      if (g_win < 2) return 2;
      if (g_win > 64) return 64;
      return int'(g_win);
   endfunction

   task automatic clear_window();
      n_samples = 0;
      ring_ptr = 0;
      wsum = 0;
      wsq = 0;
   endtask

   task automatic push_accel(longint z);
      int unsigned len, p;
      longint unsigned n, s;
      len = win_len();
      p = ring_ptr % len;
      if (n_samples >= len) begin
         wsum -= ring[p];
         wsq -= longint'(ring[p] * ring[p]);
      end else begin
         n_samples++;
      end
      ring[p] = z;
      wsum += z;
      wsq += longint'(z * z);
      ring_ptr = (p + 1) % len;
      if (n_samples <= 1) begin
         vib_var = 0;
      end else begin
         n = n_samples;
         s = labs(wsum);
         vib_var = (n * wsq - s * s) / (n * (n - 1));
         if (vib_var > 64'hF_FFFF_FFFF) vib_var = 64'hF_FFFF_FFFF;
      end
   endtask

   task automatic govern(gov_item_type it);
      longint z;
      longint unsigned m;
      gov_cmd_type r;
      case (it.op)
         OP_RAY: begin
            if (it.rv && labs(it.ang) < g_sector && it.lat < g_corr && it.fwd < run_min)
               run_min = it.fwd;
            if (it.lr) begin
               nearest = run_min;
               run_min = 999000;
            end
         end
         OP_IMU: begin
            z = longint'(it.az) - g_grav;
            if (z > 262143) z = 262143;
            if (z < -262144) z = -262144;
            pitch_h = it.pitch;
            roll_h = it.roll;
            push_accel(z);
         end
         OP_CMD: begin
            m = (prox_q() * tilt_q()) >> 15;
            m = (m * vib_q()) >> 15;
            if (m > 32768) m = 32768;
            r.lx = it.cx > 0 ? scale_q(it.cx, m) : it.cx;
            r.ly = scale_q(it.cy, m);
            r.wz = scale_q(it.cw, m);
            r.mult = 16'(m);
            scaled_cmds = {scaled_cmds, r};
         end
         default: ;
      endcase
   endtask

   task automatic add_item(gov_item_type it);
      govern(it);
      pending = {pending, it};
      items_sent++;
   endtask

   task automatic csr_write(logic [2:0] idx, longint unsigned v);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v[35:0];
      case (idx)
         REG_WARN:     g_warn = v & 'hFFFF;
         REG_CRIT:     g_crit = v & 'hFFFF;
         REG_INCLINE:  g_incl = v & 'h7FF;
         REG_WINDOW: begin
            if ((v & 'h7F) != g_win) clear_window();
            g_win = v & 'h7F;
         end
         REG_VAR_MAX:  g_vmax = v & 64'hF_FFFF_FFFF;
         REG_SECTOR:   g_sector = v & 'hFFF;
         REG_CORRIDOR: g_corr = v & 'hFFFF;
         REG_GRAVITY:  g_grav = longint'(signed'(19'(v)));
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      while (pending.size() != 0 || scaled_cmds.size() != 0 || req.valid)
         @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   function automatic int rnd(int lo, int hi);
      return lo + int'($urandom_range(hi - lo));
   endfunction

   function automatic int clip(int v, int lo, int hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic gov_item_type noise_item();
      gov_item_type it;
      it.op = 2'($urandom_range(3));
      it.ang = 13'(rnd(-3142, 3142));
      it.fwd = 17'(rnd(-65535, 65535));
      it.lat = 16'($urandom_range(65535));
      it.rv = 1'($urandom);
      it.lr = 1'($urandom);
      it.pitch = 13'(rnd(-3142, 3142));
      it.roll = 13'(rnd(-3142, 3142));
      it.az = 19'(rnd(-200000, 200000));
      it.cx = 16'($urandom);
      it.cy = 16'($urandom);
      it.cw = 16'($urandom);
      return it;
   endfunction

   task automatic random_items(int count, int amp);
      gov_item_type it;
      int start, nr, sel, lim;
      start = items_sent;
      while (items_sent - start < count) begin
         it = noise_item();
         sel = $urandom_range(99);
         if (sel < 35) begin
            nr = rnd(1, 6);
            for (int k = 0; k < nr; k++) begin
               it = noise_item();
               it.op = OP_RAY;
               it.rv = $urandom_range(9) != 0;
               lim = int'(g_sector) + 200;
               it.ang = 13'(clip(rnd(-lim, lim), -3142, 3142));
               it.lat = 16'(clip(rnd(0, int'(g_corr) + 300), 0, 65535));
               it.fwd = 17'(clip(rnd(-500, int'(g_warn) + 1000), -65535, 65535));
               it.lr = (k == nr - 1);
               add_item(it);
            end
         end else if (sel < 60) begin
            it.op = OP_IMU;
            if ($urandom_range(9) != 0) begin
               lim = 2 * int'(g_incl) + 1;
               it.pitch = 13'(clip(rnd(-lim, lim), -3142, 3142));
               it.roll = 13'(clip(rnd(-lim, lim), -3142, 3142));
               it.az = 19'(clip(int'(g_grav) + rnd(-amp, amp), -200000, 200000));
            end
            add_item(it);
         end else if (sel < 92) begin
            it.op = OP_CMD;
            add_item(it);
         end else begin
            if (sel >= 97) it.op = OP_SPARE;
            add_item(it);
         end
      end
   endtask

   task automatic run_phase(longint unsigned warn, longint unsigned crit,
                            longint unsigned incl, longint unsigned win,
                            longint unsigned vmax, longint unsigned sector,
                            longint unsigned corr, int grav, int amp, int count);
      drain();
      csr_write(REG_WARN, warn);
      csr_write(REG_CRIT, crit);
      csr_write(REG_INCLINE, incl);
      csr_write(REG_WINDOW, win);
      csr_write(REG_VAR_MAX, vmax);
      csr_write(REG_SECTOR, sector);
      csr_write(REG_CORRIDOR, corr);
      csr_write(REG_GRAVITY, longint'(grav) & 'h7FFFF);
      random_items(count, amp);
   endtask

   task automatic directed_items();
      gov_item_type it;
      it = noise_item();
      it.op = OP_RAY; it.rv = 1; it.lr = 0; it.lat = 0; it.ang = 0; it.fwd = -65535;
      add_item(it);
      it.ang = -3142; it.fwd = 65535; it.lat = 65535; add_item(it);
      it.ang = 3142; it.lr = 1; add_item(it);
      it.ang = 10; it.lat = 10; it.fwd = 1200; it.lr = 1; add_item(it);
      it.op = OP_CMD; it.cx = 32767; it.cy = -32768; it.cw = 32767; add_item(it);
      it.cx = -32768; it.cy = 32767; it.cw = -32768; add_item(it);
      it.cx = 0; it.cy = 0; it.cw = 0; add_item(it);
      // scan with nothing accepted
      it.op = OP_RAY; it.rv = 0; it.lr = 1; add_item(it);
      it.op = OP_SPARE; add_item(it);
      it.op = OP_IMU; it.pitch = 3142; it.roll = -3142; it.az = 200000; add_item(it);
      it.pitch = -3142; it.roll = 3142; it.az = -200000; add_item(it);
      it.pitch = 200; it.roll = -250; it.az = 9810; add_item(it);
      it.op = OP_CMD; it.cx = 32767; it.cy = 1; it.cw = -1; add_item(it);
      it.op = OP_IMU; it.pitch = 0; it.roll = 0; it.az = 12000; add_item(it);
      it.op = OP_CMD; it.cx = 1000; it.cy = -1000; it.cw = 5000; add_item(it);
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else if (!req.valid || req_fire) begin
         if (req_gap > 0) begin
            req.valid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (pending.size() != 0) begin
            gov_item_type it;
            it = pending[0];
            pending.delete(0);
            req.valid <= 1'b1;
            req.op <= it.op;
            req.ray_angle_mrad <= it.ang;
            req.ray_forward_mm <= it.fwd;
            req.ray_lateral_mm <= it.lat;
            req.ray_valid <= it.rv;
            req.last_ray <= it.lr;
            req.pitch_mrad <= it.pitch;
            req.roll_mrad <= it.roll;
            req.accel_z <= it.az;
            req.cmd_linear_x <= it.cx;
            req.cmd_linear_y <= it.cy;
            req.cmd_angular_z <= it.cw;
            if (!quiet && $urandom_range(5) == 0) req_gap <= rnd(1, 4);
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // result back-pressure
   always @(negedge clock) begin
      if (quiet || reset) begin
         rsp.ready <= 1'b1;
      end else if (rsp_stall > 0) begin
         rsp.ready <= 1'b0;
         rsp_stall <= rsp_stall - 1;
      end else begin
         rsp.ready <= 1'b1;
         if ($urandom_range(4) == 0) rsp_stall <= rnd(1, 4);
      end
   end

   task automatic report(string what, longint got, longint want);
      $display("MISMATCH %s: got %0d, expected %0d (command %0d)", what, got, want,
               cmds_checked);
      errors++;
   endtask

   // monitor
   always @(posedge clock) begin
      gov_cmd_type want;
      cycles <= cycles + 1;
      req_fire <= req.valid && req.ready;
      if (!reset && rsp.valid && rsp.ready) begin
         if (scaled_cmds.size() == 0) begin
            report("unexpected result, multiplier", rsp.multiplier, -1);
         end else begin
            want = scaled_cmds[0];
            scaled_cmds.delete(0);
            if (rsp.out_linear_x !== want.lx) report("out_linear_x", rsp.out_linear_x, want.lx);
            if (rsp.out_linear_y !== want.ly) report("out_linear_y", rsp.out_linear_y, want.ly);
            if (rsp.out_angular_z !== want.wz)
               report("out_angular_z", rsp.out_angular_z, want.wz);
            if (rsp.multiplier !== want.mult) report("multiplier", rsp.multiplier, want.mult);
         end
         cmds_checked <= cmds_checked + 1;
      end
      if (cycles > 1000000) begin
         $display("timeout with %0d commands outstanding", scaled_cmds.size());
         $display("rover_speed_safety_governor_top verification failed");
         $finish;
      end
   end

   initial begin
      req.valid = 1'b0;
      req.op = OP_RAY;
      req.ray_angle_mrad = '0;
      req.ray_forward_mm = '0;
      req.ray_lateral_mm = '0;
      req.ray_valid = 1'b0;
      req.last_ray = 1'b0;
      req.pitch_mrad = '0;
      req.roll_mrad = '0;
      req.accel_z = '0;
      req.cmd_linear_x = '0;
      req.cmd_linear_y = '0;
      req.cmd_angular_z = '0;
      rsp.ready = 1'b0;
      g_warn = 2000; g_crit = 600; g_incl = 314; g_win = 50; g_vmax = 4000000;
      g_sector = 524; g_corr = 400; g_grav = 9810;
      run_min = 999000; nearest = 999000; pitch_h = 0; roll_h = 0;
      clear_window();
      vib_var = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      directed_items();
      random_items(220, 3000);
      run_phase(65535, 0, 1571, 2, 1, 3142, 65535, -200000, 200000, 230);
      run_phase(0, 65535, 1, 64, 64'd40000000000, 0, 0, 200000, 100, 220);
      run_phase(1500, 1500, 400, 0, 2000000, 800, 500, 9810, 2000, 230);
      run_phase(2500, 300, 300, 127, 10000000, 600, 350, 9810, 5000, 230);
      run_phase(3000, 200, 600, 8, 500000, 1000, 800, -9810, 1500, 230);
      run_phase(1800, 900, 200, 16, 3000000, 300, 250, 0, 3000, 230);
      drain();
      quiet = 1;
      run_phase(2000, 600, 314, 50, 4000000, 524, 400, 9810, 3000, 230);
      drain();

      $display("%0d items sent over eight register settings, %0d scaled commands checked",
               items_sent, cmds_checked);
      if (errors == 0) begin
         $display("rover_speed_safety_governor_top verification clean");
      end else begin
         $display("%0d mismatches", errors);
         $display("rover_speed_safety_governor_top verification failed");
      end
      $finish;
   end

endmodule
